>>> design/ncf_pkg.sv
// Shared types and constants for the negative cycle finder.
package ncf_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DIST_W    = 40;
    localparam int WEIGHT_W  = 32;

    typedef struct packed {
        logic [31:0] coefficient;
        logic        last_entry;
    } t_in_item;

    typedef struct packed {
        logic [5:0] vertex;
        logic       last_vertex;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_LOG,
        ST_CLEAR,
        ST_RD,
        ST_RELAX,
        ST_WALK,
        ST_LIST,
        ST_HEAD,
        ST_EMIT,
        ST_NONE
    } t_state;

endpackage

>>> design/ncf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ncf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/ncf_log2.sv
// Iterative log2 of an unsigned Q16.16 value into a signed Q8.24 weight.
module ncf_log2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_coef,
    output logic        o_done,
    output logic [31:0] o_weight
);
    import ncf_pkg::*;

    logic [32:0] r_m;
    logic [23:0] r_frac;
    logic [5:0]  r_p;
    logic [4:0]  r_step;
    logic        r_busy;
    logic        r_zero;
    logic [65:0] sq;
    logic [32:0] msq;
    logic [4:0]  lead;
    logic [31:0] norm;

    always_comb begin
        lead = 5'd0;
        for (int b = 0; b < 32; b++) begin
            if (i_coef[b]) begin
                lead = 5'(b);
            end
        end
        norm = i_coef << (5'd31 - lead);
    end

    assign sq  = r_m * r_m;
    assign msq = sq[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_coef != 32'd0);
                o_done <= (i_coef == 32'd0);
                r_zero <= (i_coef == 32'd0);
                r_m    <= {1'b0, norm};
                r_p    <= {1'b0, lead};
                r_frac <= '0;
                r_step <= '0;
            end else if (r_busy) begin
                // Squaring past 2.0 yields a one bit and halves the mantissa.
                if (msq[32]) begin
                    r_m    <= {1'b0, msq[32:1]};
                    r_frac <= {r_frac[22:0], 1'b1};
                end else begin
                    r_m    <= msq;
                    r_frac <= {r_frac[22:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
                if (r_step == 5'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_weight = r_zero ? 32'h8000_0000 : {8'(r_p) - 8'd16, r_frac};
endmodule

>>> design/negative_cycle_finder_top.sv
// Top level of the negative cycle finder: load, Bellman-Ford passes, cycle listing.
// Each matrix entry holds busy high while the 24-step iterative log2 runs and its
// weight is written; a zero coefficient skips the iteration. The last entry then
// starts the Bellman-Ford passes: every edge relaxation reads the weight memory in ST_RD
// and updates the distances in ST_RELAX. The predecessor walk and the listing follow;
// the results then come one per cycle on o_valid, the last one while busy is already
// low, and the receiver cannot stall them.
module negative_cycle_finder_top #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ncf_pkg::t_in_item    i_item,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_data,
    output logic                 o_valid,
    output ncf_pkg::t_out_item   o_item
);
    import ncf_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
    localparam int CW    = $clog2(CELLS);
    localparam logic signed [DIST_W-1:0] FLOOR = {1'b1, {(DIST_W-1){1'b0}}};

    t_state r_state, n_state;
    logic [5:0]  r_cfg;
    logic [CW-1:0] r_pos;
    logic        r_last;
    logic [VW:0] r_n;
    logic [VW-1:0] r_from, r_to, r_pass, r_cnt, r_cur, r_start, r_lr;
    logic        r_lr_v;
    logic [MAX_VERTICES-1:0] r_pv;
    logic [VW-1:0] r_pred [MAX_VERTICES];
    logic [VW-1:0] r_list [MAX_VERTICES];
    logic [VW:0]   r_k;
    logic signed [DIST_W-1:0] r_dist [MAX_VERTICES];
    logic        log_done;
    logic [31:0] log_w, w_rd;
    logic        w_we;
    logic [CW-1:0] w_ra;
    logic signed [DIST_W:0] cand;
    logic        relax;
    logic        row_end, pass_end, last_edge;

    ncf_log2 u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(start && !busy), .i_coef(i_item.coefficient),
        .o_done(log_done), .o_weight(log_w)
    );

    assign w_we = log_done;
    assign w_ra = CW'(int'(r_from) * int'(r_n) + int'(r_to));

    ncf_ram #(.WIDTH(WEIGHT_W), .DEPTH(CELLS)) u_wmem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_pos), .i_wdata(log_w),
        .i_raddr(w_ra), .o_rdata(w_rd)
    );

    assign busy = (r_state != ST_LOAD);
    assign cand = {r_dist[r_from][DIST_W-1], r_dist[r_from]}
                  + {{(DIST_W-31){w_rd[31]}}, w_rd};
    assign relax = $signed(cand) < $signed({r_dist[r_to][DIST_W-1], r_dist[r_to]});
    assign row_end   = (32'(r_to) + 1 == 32'(r_n));
    assign pass_end  = row_end && (32'(r_from) + 1 == 32'(r_n));
    assign last_edge = pass_end && (32'(r_pass) + 1 == 32'(r_n));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:    if (start) n_state = ST_LOG;
            ST_LOG:     if (log_done) n_state = r_last ? ST_CLEAR : ST_LOAD;
            ST_CLEAR:   n_state = ST_RD;
            ST_RD:      n_state = ST_RELAX;
            ST_RELAX: begin
                if (last_edge) begin
                    n_state = (r_lr_v || relax) ? ST_WALK : ST_NONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_WALK: begin
                if (!r_pv[r_cur]) n_state = ST_NONE;
                else if (32'(r_cnt) + 1 == 32'(r_n)) n_state = ST_LIST;
            end
            ST_LIST: begin
                // A chain that has not closed once the list is full cannot close in time.
                if (!r_pv[r_cur]) n_state = ST_NONE;
                else if (r_pred[r_cur] == r_start) n_state = ST_HEAD;
                else if (32'(r_k) == MAX_VERTICES) n_state = ST_NONE;
            end
            ST_HEAD:    n_state = ST_EMIT;
            ST_EMIT:    if (r_k == (VW+1)'(1)) n_state = ST_LOAD;
            ST_NONE:    n_state = ST_LOAD;
            default:    n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cfg   <= 6'd1;
            r_pos   <= '0;
            r_lr_v  <= 1'b0;
            r_pv    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state inside {ST_HEAD, ST_EMIT, ST_NONE});
            if (i_cfg_we) r_cfg <= i_cfg_data;
            case (r_state)
                ST_LOAD: if (start) r_last <= i_item.last_entry;
                ST_LOG: begin
                    // The last entry ends the load, so the next load starts at cell zero.
                    if (log_done) begin
                        r_pos <= (r_last || 32'(r_pos) + 1 == CELLS) ? '0 : r_pos + 1'b1;
                    end
                end
                ST_CLEAR: begin
                    r_n <= (r_cfg == 0) ? (VW+1)'(1) : (32'(r_cfg) > MAX_VERTICES)
                           ? (VW+1)'(MAX_VERTICES) : (VW+1)'(r_cfg);
                    r_pv <= '0;
                    r_lr_v <= 1'b0;
                    r_from <= '0; r_to <= '0; r_pass <= '0;
                    for (int v = 0; v < MAX_VERTICES; v++) r_dist[v] <= '0;
                end
                ST_RELAX: begin
                    if (relax) begin
                        r_dist[r_to] <= ($signed(cand) < $signed({FLOOR[DIST_W-1], FLOOR}))
                                        ? FLOOR : cand[DIST_W-1:0];
                        r_pred[r_to] <= r_from;
                        r_pv[r_to] <= 1'b1;
                        r_lr <= r_to;
                        r_cur <= r_to;
                    end else begin
                        r_cur <= r_lr;
                    end
                    // Only the final pass decides whether a cycle exists.
                    if (pass_end && !last_edge) r_lr_v <= 1'b0;
                    else if (relax) r_lr_v <= 1'b1;
                    if (row_end) begin
                        r_to <= '0;
                        if (pass_end) begin
                            r_from <= '0;
                            r_pass <= r_pass + 1'b1;
                        end else r_from <= r_from + 1'b1;
                    end else r_to <= r_to + 1'b1;
                    r_cnt <= '0;
                end
                ST_WALK: begin
                    r_cur <= r_pred[r_cur];
                    r_cnt <= r_cnt + 1'b1;
                    if (32'(r_cnt) + 1 == 32'(r_n)) begin
                        r_start <= r_pred[r_cur];
                        r_list[0] <= r_pred[r_cur];
                        r_k <= (VW+1)'(1);
                    end
                end
                ST_LIST: begin
                    // The closing vertex equals the start and is not stored again.
                    r_cur <= r_pred[r_cur];
                    if (r_pred[r_cur] != r_start && 32'(r_k) < MAX_VERTICES) begin
                        r_list[VW'(r_k)] <= r_pred[r_cur];
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_HEAD: begin
                    o_item.vertex <= 6'(r_start) + 6'd1;
                    o_item.last_vertex <= 1'b0;
                end
                ST_EMIT: begin
                    o_item.vertex <= 6'(r_list[VW'(r_k - 1'b1)]) + 6'd1;
                    o_item.last_vertex <= (r_k == (VW+1)'(1));
                    r_k <= r_k - 1'b1;
                end
                ST_NONE: begin
                    o_item.vertex <= 6'd0;
                    o_item.last_vertex <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

>>> design/ncf_checker.sv
// Port-level checker for the negative cycle finder, bound to the top level.
module ncf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input ncf_pkg::t_out_item o_item
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result outside a run");
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.vertex == 6'd0 |-> o_item.last_vertex)
        else $error("no-cycle marker not final");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept did not raise busy");
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last_vertex |=> !o_valid) else $error("result after last");
endmodule

bind negative_cycle_finder_top ncf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_item(o_item)
);

>>> tb/negative_cycle_finder_top_tb.sv
// Testbench for negative_cycle_finder_top: loads fixed and random matrices and checks the cycle listings.
module negative_cycle_finder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ncf_pkg::*;

    localparam int MAX_V     = 32;
    localparam int CELLS     = MAX_V * MAX_V;
    localparam int DRAIN_CYC = 40;

    // Holds its own copy of the weight matrix and the vertex count, predicts the
    // listing each run produces, and checks the listings as they come out.
    class ncf_cycle_tracker;
        int          weights [CELLS];
        int unsigned load_pos;
        int unsigned vertex_count;
        t_out_item   expected_listing [$];
        int          mismatches;
        int          failures;

        function new();
            load_pos     = 0;
            vertex_count = 1;
            mismatches   = 0;
            failures     = 0;
        endfunction

        function void set_count(bit [5:0] value);
            vertex_count = value;
        endfunction

        // Signed Q8.24 log2 of an unsigned Q16.16 value, by repeated squaring.
        function int log2_q824(bit [31:0] coef);
            int        lead;
            bit [63:0] mant;
            bit [23:0] frac;
            if (coef == 0)
                return int'(32'h8000_0000);
            lead = 31;
            while (coef[lead] == 1'b0)
                lead--;
            mant = 64'(coef) << (31 - lead);
            frac = '0;
            for (int b = 0; b < FRAC_BITS; b++) begin
                mant = (mant * mant) >> 31;
                frac = frac << 1;
                if (mant >= 64'h1_0000_0000) begin
                    frac[0] = 1'b1;
                    mant = mant >> 1;
                end
            end
            return (lead - 16) * (2 ** 24) + int'({8'h00, frac});
        endfunction

        function void push_no_cycle();
            t_out_item r;
            r.vertex      = '0;
            r.last_vertex = 1'b1;
            expected_listing = {expected_listing, r};
        endfunction

        function void search_cycle();
            int unsigned n;
            longint      shortest [MAX_V];
            int          pred [MAX_V];
            bit          pred_ok [MAX_V];
            int          relaxed;
            bit          relaxed_ok;
            int          from_v;
            int          to_v;
            longint      cand;
            int          walk;
            int          cur;
            int          path [$];
            t_out_item   r;
            n = vertex_count;
            if (n < 1) n = 1;
            if (n > MAX_V) n = MAX_V;
            for (int v = 0; v < MAX_V; v++) begin
                shortest[v] = 0;
                pred[v]     = 0;
                pred_ok[v]  = 1'b0;
            end
            relaxed    = 0;
            relaxed_ok = 1'b0;
            for (int unsigned p = 0; p < n; p++) begin
                relaxed_ok = 1'b0;
                for (int unsigned j = 0; j < n * n; j++) begin
                    from_v = j / n;
                    to_v   = j % n;
                    cand   = shortest[from_v] + longint'(weights[j]);
                    if (shortest[to_v] > cand) begin
                        shortest[to_v] = (cand < -(64'sd1 <<< 39)) ? -(64'sd1 <<< 39) : cand;
                        pred[to_v]     = from_v;
                        pred_ok[to_v]  = 1'b1;
                        relaxed        = to_v;
                        relaxed_ok     = 1'b1;
                    end
                end
            end
            if (!relaxed_ok) begin
                push_no_cycle();
                return;
            end
            // Step back n times so the walk is sure to sit on the cycle itself.
            walk = relaxed;
            for (int unsigned i = 0; i < n; i++) begin
                if (!pred_ok[walk]) begin
                    push_no_cycle();
                    return;
                end
                walk = pred[walk];
            end
            path = {path, walk};
            cur = walk;
            forever begin
                if (!pred_ok[cur] || path.size() >= MAX_V + 1) begin
                    push_no_cycle();
                    return;
                end
                cur = pred[cur];
                path = {path, cur};
                if (cur == walk)
                    break;
            end
            // The chain runs backward; the listing goes forward.
            for (int i = path.size() - 1; i >= 0; i--) begin
                r.vertex      = 6'(path[i] + 1);
                r.last_vertex = (i == 0);
                expected_listing = {expected_listing, r};
            end
        endfunction

        function void note_coefficient(t_in_item item);
            weights[load_pos] = log2_q824(item.coefficient);
            load_pos = (load_pos + 1) % CELLS;
            if (!item.last_entry)
                return;
            load_pos = 0;
            search_cycle();
        endfunction

        function void check_vertex(t_out_item got);
            t_out_item want;
            if (expected_listing.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: vertex %0d last %0b",
                             got.vertex, got.last_vertex);
                return;
            end
            want = expected_listing.pop_front();
            if (got.vertex !== want.vertex || got.last_vertex !== want.last_vertex) begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected vertex %0d last %0b, got vertex %0d last %0b",
                             want.vertex, want.last_vertex, got.vertex, got.last_vertex);
            end
        endfunction

        function int pending();
            return expected_listing.size();
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       start      = 1'b0;
    logic       busy;
    t_in_item   i_item     = '0;
    logic       i_cfg_we   = 1'b0;
    logic [5:0] i_cfg_data = '0;
    logic       o_valid;
    t_out_item  o_item;

    ncf_cycle_tracker tracker = new();
    int unsigned      written_prefix = 0;
    int unsigned      random_items = 0;

    negative_cycle_finder_top #(.MAX_VERTICES(MAX_V)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_item(o_item)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            tracker.check_vertex(o_item);
    end

    initial begin
        #10_000_000;
        $display("negative_cycle_finder_top_tb failed");
        $finish;
    end

    // Leaves start high after the accepting edge so back-to-back entries need no gap.
    task automatic send_entry(bit [31:0] coef, bit last);
        int gap;
        t_in_item item;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.coefficient = coef;
        item.last_entry  = last;
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
        tracker.note_coefficient(item);
        if (last)
            start <= 1'b0;
    endtask

    task automatic write_count(bit [5:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_count(value);
    endtask

    task automatic wait_drained();
        while (tracker.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_coefficient();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 32'h0;
        if (sel == 1) return $urandom();
        if (sel <= 4) return $urandom_range(1, 32'hFFFF);
        return 32'h10000 + $urandom_range(0, 16000) - 8000;
    endfunction

    task automatic run_matrix(bit [5:0] count, int unsigned entries, bit random_part);
        write_count(count);
        for (int unsigned e = 0; e < entries; e++) begin
            send_entry(pick_coefficient(), e == entries - 1);
            if (random_part) random_items++;
        end
        if (entries > written_prefix) written_prefix = (entries > CELLS) ? CELLS : entries;
        wait_drained();
    endtask

    task automatic run_fixed(bit [5:0] count, bit [31:0] coefs [$]);
        write_count(count);
        foreach (coefs[i])
            send_entry(coefs[i], i == coefs.size() - 1);
        if (coefs.size() > written_prefix) written_prefix = coefs.size();
        wait_drained();
    endtask

    initial begin
        int unsigned n;
        int unsigned entries;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A zero coefficient on a self loop; a count of zero behaves as one vertex.
        run_fixed(6'd0, '{32'h0});
        run_fixed(6'd1, '{32'h0001_0000});
        run_fixed(6'd1, '{32'hFFFF_FFFF});
        run_fixed(6'd2, '{32'h1, 32'h1_0000, 32'h1_0000, 32'h1});
        // Exchange rates whose product is exactly one give no cycle.
        run_fixed(6'd2, '{32'h1_0000, 32'h8000, 32'h2_0000, 32'h1_0000});
        run_fixed(6'd3, '{32'hFFFF_FFFF, 32'h8000, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000,
                          32'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});

        while (random_items < 340) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
            entries = n * n;
            // Short loads reuse cells left over from earlier runs.
            if (written_prefix >= n * n && $urandom_range(0, 6) == 0)
                entries = $urandom_range(1, n * n);
            run_matrix(6'(n), entries, 1'b1);
        end

        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("negative_cycle_finder_top_tb passed");
        else
            $display("negative_cycle_finder_top_tb failed");
        $finish;
    end

endmodule
